/* hdl/stack_machine_op_unit_macros.svh */
// Assertion macros for the stack machine op unit.
`ifndef STACK_MACHINE_OP_UNIT_MACROS_SVH
`define STACK_MACHINE_OP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SM_ASSERT(label, clk, rst, prop, msg)
`define SM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* hdl/smop_pkg.sv */
// Package: types, codes and constants of the stack machine op unit.
package smop_pkg;
  localparam int StackDepthDefault = 32;
  localparam logic [31:0] CharMax = 32'd127;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0, CMD_MUL = 3'd1, CMD_MOD = 3'd2,
    CMD_PCHAR = 3'd3, CMD_PSTR = 3'd4, CMD_ROTL = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_SHORT = 3'd1, ST_DIVZERO = 3'd2, ST_RANGE = 3'd3, ST_FULL = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_MUL, S_DIV, S_DIVFIX, S_WB,
    S_STR_RD, S_STR_CHK, S_ROT_RD, S_ROT_MOVE, S_ROT_TOP, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic       has_char;
    logic [6:0] char_code;
    logic       last;
  } result_t;
endpackage

/* hdl/smop_if.sv */
// Valid/ready channel interfaces for commands and results.
interface smop_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic signed [31:0] push_value;
  modport source (output valid, command, push_value, input ready);
  modport sink (input valid, command, push_value, output ready);
endinterface

interface smop_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       has_char;
  logic [6:0] char_code;
  logic       last;
  modport source (output valid, status, has_char, char_code, last, input ready);
  modport sink (input valid, status, has_char, char_code, last, output ready);
endinterface

/* hdl/smop_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module smop_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/stack_machine_op_unit.sv */
// Stack machine op unit: RAM-held stack of 32-bit words, one command at a time.
// Paths: push, errors and unused codes go straight to S_OUT; pchar reads the top; mul and mod read
// two words and, but for mod by zero, write one back; rotl walks only with two or more words.
// One command in flight: a new beat is taken in S_IDLE, once the prior command's last result is registered.
// A waiting result holds S_OUT or the pstr walk; pstr/rotl walk one entry per RAM access.
// rst (synchronous, high) empties the stack; RAM contents are left as they are.
`include "stack_machine_op_unit_macros.svh"
module stack_machine_op_unit #(
  parameter int StackDepth = smop_pkg::StackDepthDefault
) (
  input logic clk,
  input logic rst,
  smop_cmd_if.sink   cmd,
  smop_res_if.source res
);
  import smop_pkg::*;

  localparam int AW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(StackDepth);

  // control registers
  state_t state, state_next;
  logic [CW-1:0] count;       // words held
  logic [2:0]    op;          // latched command
  logic [31:0]   top_w, nxt_w;
  logic [CW-1:0] idx;         // walk index (pstr / rotl)
  logic [31:0]   prod;
  // divider: unsigned restoring, one quotient bit a cycle
  logic [31:0]   dv_rem, dv_num, dv_den;
  logic [5:0]    dv_cnt;
  logic          dv_neg;
  logic          obuf_valid;
  result_t       obuf;

  // pending final-result fields
  logic [2:0] res_stat;
  logic       res_has;
  logic [6:0] res_chr;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  smop_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic printable(input logic [31:0] w);
    printable = (w != 32'd0) && (w <= CharMax);
  endfunction

  function automatic logic [2:0] first_status(input logic [2:0] c, input logic [CW-1:0] n);
    logic [2:0] s;
    s = ST_OK;
    case (c)
      CMD_PUSH: if (n == DepthC) s = ST_FULL;
      CMD_MUL, CMD_MOD: if (n < CW'(2)) s = ST_SHORT;
      CMD_PCHAR: if (n == '0) s = ST_SHORT;
      default: s = ST_OK;
    endcase
    first_status = s;
  endfunction

  logic cmd_acc;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;

  // result register loads the final result in S_OUT; pstr chars also emitted from S_STR_CHK
  logic          emit;
  result_t       emit_r;
  logic          out_free;
  assign out_free = !obuf_valid || res.ready;

  logic [32:0] dv_trial;
  assign dv_trial = {dv_rem, dv_num[31]} - {1'b0, dv_den};

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          state_next = S_OUT;
          case (cmd.command)
            CMD_MUL, CMD_MOD: if (count >= CW'(2)) state_next = S_RD1;
            CMD_PCHAR: if (count != '0) state_next = S_RD1;
            CMD_PSTR: if (count != '0) state_next = S_STR_RD;
            CMD_ROTL: if (count > CW'(1)) state_next = S_ROT_RD;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_RD1: state_next = (op == CMD_PCHAR) ? S_OUT : S_RD2;
      S_RD2: begin
        if (op == CMD_MUL) state_next = S_MUL;
        else if (top_w == 32'd0) state_next = S_OUT;
        else state_next = S_DIV;
      end
      S_MUL: state_next = S_WB;
      S_DIV: if (dv_cnt == 6'd31) state_next = S_DIVFIX;
      S_DIVFIX: state_next = S_WB;
      S_WB: state_next = S_OUT;
      S_STR_RD: state_next = S_STR_CHK;
      S_STR_CHK: begin
        if (out_free) begin
          if (!printable(rdata) || idx == '0) state_next = S_OUT;
          else if (printable(rdata) && idx == CW'(1)) state_next = S_OUT;
          else state_next = S_STR_RD;
        end
      end
      S_ROT_RD: state_next = S_ROT_MOVE;
      S_ROT_MOVE: state_next = (idx == '0) ? S_ROT_TOP : S_ROT_MOVE;
      S_ROT_TOP: state_next = S_OUT;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM addressing and emits
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = 32'd0;
    raddr = '0;
    emit = 1'b0;
    emit_r = '0;
    case (state)
      S_IDLE: begin
        raddr = AW'(count - CW'(1));
        if (cmd_acc && cmd.command == CMD_PUSH && count != DepthC) begin
          we = 1'b1;
          waddr = AW'(count);
          wdata = cmd.push_value;
        end
      end
      S_RD1: raddr = AW'(count - CW'(2));
      S_WB: begin
        we = 1'b1;
        waddr = AW'(count - CW'(2));
        wdata = nxt_w;
      end
      S_STR_RD: raddr = AW'(idx - CW'(1));
      S_STR_CHK: begin
        // keep the word on the read port while the output is stalled
        raddr = AW'(idx - CW'(1));
        if (out_free && printable(rdata)) begin
          emit = 1'b1;
          emit_r.has_char = 1'b1;
          emit_r.char_code = rdata[6:0];
        end
      end
      S_ROT_RD: raddr = AW'(idx - CW'(1));
      S_ROT_MOVE: begin
        // first pass only latches the top; then the word read last cycle moves one up
        raddr = AW'(idx - CW'(1));
        if (idx != count - CW'(1)) begin
          we = 1'b1;
          waddr = AW'(idx + CW'(1));
          wdata = rdata;
        end
      end
      S_ROT_TOP: begin
        we = 1'b1;
        waddr = '0;
        wdata = top_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      obuf_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (obuf_valid && res.ready) obuf_valid <= 1'b0;
      if (emit) begin
        obuf_valid <= 1'b1;
      end
      if (state == S_OUT && out_free) obuf_valid <= 1'b1;
      if (cmd_acc && cmd.command == CMD_PUSH && count != DepthC) count <= count + CW'(1);
      if (state == S_WB) count <= count - CW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (emit) obuf <= emit_r;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          op <= cmd.command;
          idx <= count;
          res_stat <= first_status(cmd.command, count);
          res_has <= 1'b0;
          res_chr <= 7'd0;
        end
      end
      S_RD1: begin
        top_w <= rdata;
        if (op == CMD_PCHAR) begin
          if (printable(rdata)) begin
            res_stat <= ST_OK;
            res_has <= 1'b1;
            res_chr <= rdata[6:0];
          end else begin
            res_stat <= ST_RANGE;
          end
        end
      end
      S_RD2: begin
        nxt_w <= rdata;
        prod <= rdata * top_w;
        if (op == CMD_MOD && top_w == 32'd0) res_stat <= ST_DIVZERO;
        dv_neg <= rdata[31];
        dv_num <= rdata[31] ? (32'd0 - rdata) : rdata;
        dv_den <= top_w[31] ? (32'd0 - top_w) : top_w;
        dv_rem <= 32'd0;
        dv_cnt <= 6'd0;
      end
      S_MUL: nxt_w <= prod;
      S_DIV: begin
        if (!dv_trial[32]) dv_rem <= dv_trial[31:0];
        else dv_rem <= {dv_rem[30:0], dv_num[31]};
        dv_num <= {dv_num[30:0], 1'b0};
        dv_cnt <= dv_cnt + 6'd1;
      end
      S_DIVFIX: nxt_w <= dv_neg ? (32'd0 - dv_rem) : dv_rem;
      S_STR_CHK: if (out_free && printable(rdata)) idx <= idx - CW'(1);
      S_ROT_RD: idx <= idx - CW'(1);
      S_ROT_MOVE: begin
        if (idx == CW'(count - CW'(1))) top_w <= rdata;
        if (idx != '0) idx <= idx - CW'(1);
      end
      default: ;
    endcase
    if (state == S_OUT && out_free) begin
      obuf.status <= res_stat;
      obuf.has_char <= res_has;
      obuf.char_code <= res_chr;
      obuf.last <= 1'b1;
    end
  end

  assign res.valid = obuf_valid;
  assign res.status = obuf.status;
  assign res.has_char = obuf.has_char;
  assign res.char_code = obuf.char_code;
  assign res.last = obuf.last;

  logic res_stall;
  assign res_stall = res.valid && !res.ready;

  `SM_ASSERT(a_count_bound, clk, rst, count <= DepthC, "stack count above depth")
  `SM_ASSERT(a_ready_idle, clk, rst, cmd.ready |-> state == S_IDLE, "ready outside idle")
  `SM_ASSERT(a_hold, clk, rst, res_stall |=> (res.valid && $stable(res.status)), "beat dropped")
  `SM_ASSERT_RST(a_rst, clk, rst |=> (count == '0 && !res.valid), "reset did not empty stack")
endmodule

/* tb/stack_machine_op_unit_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts stack unit results from observed command beats and compares them.
module stack_machine_op_unit_checker #(
  parameter int StackDepth = smop_pkg::StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  logic [2:0]  cmd_command,
  input  logic [31:0] cmd_push_value,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [2:0]  res_status,
  input  logic        res_has_char,
  input  logic [6:0]  res_char_code,
  input  logic        res_last,
  output int          errors,
  output int          pending
);
  import smop_pkg::*;

  logic [31:0] words [StackDepth];
  int          depth;
  result_t     want_q[$];

  function automatic result_t mk(status_t st, logic hc, logic [6:0] ch, logic l);
    result_t r;
    r.status = st;
    r.has_char = hc;
    r.char_code = ch;
    r.last = l;
    return r;
  endfunction

  function automatic logic is_char(logic [31:0] w);
    return (w >= 32'd1) && (w <= CharMax);
  endfunction

  // Apply one command to the shadow stack and queue what it should answer.
  task automatic run_command(logic [2:0] c, logic [31:0] v);
    logic signed [31:0] a;
    logic signed [31:0] d;
    logic [31:0]        top;
    int                 i;
    case (c)
      CMD_PUSH: begin
        if (depth >= StackDepth) want_q.push_back(mk(ST_FULL, 1'b0, 7'd0, 1'b1));
        else begin
          words[depth] = v;
          depth++;
          want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
        end
      end
      CMD_MUL: begin
        if (depth < 2) want_q.push_back(mk(ST_SHORT, 1'b0, 7'd0, 1'b1));
        else begin
          words[depth-2] = words[depth-1] * words[depth-2];
          depth--;
          want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
        end
      end
      CMD_MOD: begin
        if (depth < 2) want_q.push_back(mk(ST_SHORT, 1'b0, 7'd0, 1'b1));
        else if (words[depth-1] == 32'd0) want_q.push_back(mk(ST_DIVZERO, 1'b0, 7'd0, 1'b1));
        else begin
          a = words[depth-2];
          d = words[depth-1];
          // most negative % -1 is zero; avoid the overflow
          words[depth-2] = (d == -32'sd1) ? 32'sd0 : a % d;
          depth--;
          want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
        end
      end
      CMD_PCHAR: begin
        if (depth == 0) want_q.push_back(mk(ST_SHORT, 1'b0, 7'd0, 1'b1));
        else if (!is_char(words[depth-1])) want_q.push_back(mk(ST_RANGE, 1'b0, 7'd0, 1'b1));
        else want_q.push_back(mk(ST_OK, 1'b1, words[depth-1][6:0], 1'b1));
      end
      CMD_PSTR: begin
        for (i = depth - 1; i >= 0 && is_char(words[i]); i--)
          want_q.push_back(mk(ST_OK, 1'b1, words[i][6:0], 1'b0));
        want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
      end
      CMD_ROTL: begin
        if (depth > 0) begin
          top = words[depth-1];
          for (i = depth - 1; i > 0; i--) words[i] = words[i-1];
          words[0] = top;
        end
        want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
      end
      default: want_q.push_back(mk(ST_OK, 1'b0, 7'd0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    got.status = res_status;
    got.has_char = res_has_char;
    got.char_code = res_char_code;
    got.last = res_last;
    if (rst) begin
      depth = 0;
      want_q.delete();
      errors <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result beat: got %p", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, exp_r, got);
            errors <= errors + 1;
          end
        end
      end
      if (cmd_valid && cmd_ready) run_command(cmd_command, cmd_push_value);
    end
    pending <= want_q.size();
  end

endmodule

/* tb/stack_machine_op_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the stack machine op unit testbench: clock, reset, stimulus, verdict.
module stack_machine_op_unit_tb;
  import smop_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   sent;
  bit   stim_done;
  bit   long_hold;  // receiver held off to back the block up
  int   rnd_left;

  smop_cmd_if cmd_ch ();
  smop_res_if res_ch ();

  stack_machine_op_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .res (res_ch.source)
  );

  stack_machine_op_unit_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_ch.valid),
    .cmd_ready     (cmd_ch.ready),
    .cmd_command   (cmd_ch.command),
    .cmd_push_value(cmd_ch.push_value),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_status    (res_ch.status),
    .res_has_char  (res_ch.has_char),
    .res_char_code (res_ch.char_code),
    .res_last      (res_ch.last),
    .errors        (errors),
    .pending       (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Command beats, directed first then random. Each slot: command and value.
  logic [2:0]  dir_cmd [$];
  logic [31:0] dir_val [$];

  task automatic add(logic [2:0] c, logic [31:0] v);
    dir_cmd.push_back(c);
    dir_val.push_back(v);
  endtask

  // Pick the next random command. Biased toward keeping printable data around
  // so pstr produces long strings; pushes are the most common command.
  task automatic pick(output logic [2:0] c, output logic [31:0] v);
    int r;
    r = $urandom_range(0, 99);
    v = $urandom();
    if (r < 40) begin
      c = CMD_PUSH;
      case ($urandom_range(0, 5))
        0, 1, 2: v = $urandom_range(1, 127);       // printable
        3:       v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))};
        4:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
    end else if (r < 50) c = CMD_MUL;
    else if (r < 62) c = CMD_MOD;
    else if (r < 74) c = CMD_PCHAR;
    else if (r < 86) c = CMD_PSTR;
    else if (r < 97) c = CMD_ROTL;
    else c = 3'($urandom_range(6, 7));  // unused codes
  endtask

  // Sender: bursts of back-to-back beats, random gaps between bursts.
  initial begin
    int          burst;
    int          gap;
    int          idx;
    logic [2:0]  c;
    logic [31:0] v;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_PUSH;
    cmd_ch.push_value = '0;
    stim_done = 1'b0;
    sent = 0;
    idx = 0;
    rnd_left = 145;

    // directed: empty-stack errors, extremes, full stack, every command
    add(CMD_MUL, 0); add(CMD_MOD, 0); add(CMD_PCHAR, 0); add(CMD_PSTR, 0);
    add(CMD_ROTL, 0);
    add(CMD_PUSH, 32'h8000_0000); add(CMD_PUSH, 32'hFFFF_FFFF); add(CMD_MOD, 0);
    add(CMD_PUSH, 32'h7FFF_FFFF); add(CMD_PUSH, 0); add(CMD_MOD, 0);
    add(CMD_PCHAR, 0); add(CMD_PUSH, 128); add(CMD_PCHAR, 0);
    add(CMD_PUSH, 32'h7FFF_FFFF); add(CMD_MUL, 0);
    add(CMD_PUSH, -32'sd7); add(CMD_PUSH, 3); add(CMD_MOD, 0);
    add(CMD_PUSH, 127); add(CMD_PUSH, 1); add(CMD_PSTR, 0); add(CMD_ROTL, 0);
    add(3'd6, 0); add(3'd7, 0);
    // fill to the top, overflow on the pushes left over, print the printable run on top
    for (int i = 0; i < StackDepthDefault; i++) add(CMD_PUSH, 32'($urandom_range(1, 127)));
    add(CMD_PSTR, 0);

    @(posedge clk);
    while (!rst) @(posedge clk);
    while (rst) @(posedge clk);

    while (idx < dir_cmd.size() || rnd_left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && (idx < dir_cmd.size() || rnd_left > 0)) begin
        if (idx < dir_cmd.size()) begin
          c = dir_cmd[idx];
          v = dir_val[idx];
          idx++;
        end else begin
          pick(c, v);
          rnd_left--;
          // occasionally drain the stack with a run of mul
          if (rnd_left % 60 == 0) for (int i = 0; i < 20; i++) add(CMD_MUL, 0);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.push_value <= v;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: own stall pattern, one long hold-off early in the run.
  initial begin
    int phase;
    res_ch.ready = 1'b0;
    long_hold = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!rst && sent == 40 && !long_hold) begin
        long_hold = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      phase++;
      case ((phase / 64) % 3)
        0:       res_ch.ready <= 1'b1;                   // no stall stretch
        1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= (phase % 5 != 0) && ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Reset, then wait for drain and give the verdict.
  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!stim_done) @(posedge clk);
    // let the checker queue the last accepted beat before polling pending
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // trailing cycles in case the block emits anything extra
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/smop_pkg.sv
hdl/smop_if.sv
hdl/smop_ram.sv
hdl/stack_machine_op_unit.sv
tb/stack_machine_op_unit_checker.sv
tb/stack_machine_op_unit_tb.sv
